>>> src/qth_pkg.sv
// ----------------------------------------------------------------------------
// qth_pkg: shared types and constants for the quaternion heading pipeline
// Word types, datapath widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qth_pkg;

	// datapath widths
	localparam int PROD_W       = 32;   // one 16x16 product
	localparam int VEC_W        = 36;   // vector components, with CORDIC growth
	localparam int MAG_W        = 33;   // magnitude, at most 2^32
	localparam int ACC_W        = 34;   // angle accumulator, 2^31 units = pi
	localparam int NORM_STEPS   = 5;    // shifts of 16, 8, 4, 2, 1
	localparam int NORM_TOP     = 31;   // larger magnitude is raised to this bit
	localparam int ATAN_ENTRIES = 31;
	localparam int ROUND_POS    = 16;   // accumulator to output angle

	localparam logic signed [ACC_W-1:0] ANGLE_PI   = ACC_W'(64'sd2147483648);
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd32768);

	// atan(2^-i), 2^31 units = pi
	localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81,
		34'sd41,        34'sd20,        34'sd10,        34'sd5,
		34'sd3,         34'sd1,         34'sd1
	};

	// input word
	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	// result word
	typedef struct packed {
		logic signed [15:0] heading_angle;
		logic               degenerate;
	} heading_t;

	// CORDIC vector and angle
	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [ACC_W-1:0] acc;
	} vec_t;

	// side flags travelling with each word
	typedef struct packed {
		logic null_vec;     // rotated axis has no xy component
		logic degenerate;   // all-zero quaternion
	} flags_t;

endpackage

>>> src/qth_form.sv
// ----------------------------------------------------------------------------
// qth_form: rotated x axis from the quaternion
// Two stages: the six products, then X = w2+x2-y2-z2 and Y = 2(xy+wz).
// ----------------------------------------------------------------------------
module qth_form (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_in,
	input  qth_pkg::quat_t                    quat,
	output logic                              valid_s2,
	output logic signed [qth_pkg::VEC_W-1:0]  vx_s2,
	output logic signed [qth_pkg::VEC_W-1:0]  vy_s2,
	output logic                              deg_s2
);

	logic signed [15:0] w, x, y, z;
	logic signed [qth_pkg::PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1;
	logic valid_s1;
	logic deg_s1;

	assign w = quat.quat_w;
	assign x = quat.quat_x;
	assign y = quat.quat_y;
	assign z = quat.quat_z;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		ww_s1  <= w * w;
		xx_s1  <= x * x;
		yy_s1  <= y * y;
		zz_s1  <= z * z;
		xy_s1  <= x * y;
		wz_s1  <= w * z;
		deg_s1 <= (quat == '0);
	end

	// stage 2: axis components
	always_ff @(posedge clk) begin
		vx_s2  <= qth_pkg::VEC_W'(ww_s1) + qth_pkg::VEC_W'(xx_s1)
		        - qth_pkg::VEC_W'(yy_s1) - qth_pkg::VEC_W'(zz_s1);
		vy_s2  <= (qth_pkg::VEC_W'(xy_s1) + qth_pkg::VEC_W'(wz_s1)) <<< 1;
		deg_s2 <= deg_s1;
	end

endmodule

>>> src/qth_norm.sv
// ----------------------------------------------------------------------------
// qth_norm: magnitude, normalising shift and half-plane pre-rotation
// The larger magnitude is raised to bit 31 by a binary shift search, one
// step per stage, then a left-half-plane vector is turned through pi.
// ----------------------------------------------------------------------------
module qth_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_in,
	input  logic signed [qth_pkg::VEC_W-1:0]  vx_in,
	input  logic signed [qth_pkg::VEC_W-1:0]  vy_in,
	input  logic                              deg_in,
	output logic                              valid_out,
	output qth_pkg::vec_t                     vec_out,
	output qth_pkg::flags_t                   flags_out
);

	localparam int NS = qth_pkg::NORM_STEPS;

	logic signed [qth_pkg::VEC_W-1:0] ax, ay;
	logic        [qth_pkg::MAG_W-1:0] mx, my;

	// element 0 is the magnitude stage, the others follow each shift step
	logic signed [qth_pkg::VEC_W-1:0] vx_sn    [NS+1];
	logic signed [qth_pkg::VEC_W-1:0] vy_sn    [NS+1];
	logic        [qth_pkg::MAG_W-1:0] m_sn     [NS+1];
	qth_pkg::flags_t                  flags_sn [NS+1];
	logic        [NS:0]               valid_sn;

	logic signed [qth_pkg::VEC_W-1:0] nvx, nvy;

	// magnitudes
	always_comb begin
		ax = vx_in[qth_pkg::VEC_W-1] ? -vx_in : vx_in;
		ay = vy_in[qth_pkg::VEC_W-1] ? -vy_in : vy_in;
		mx = ax[qth_pkg::MAG_W-1:0];
		my = ay[qth_pkg::MAG_W-1:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn[0] <= 1'b0;
		end else begin
			valid_sn[0] <= valid_in;
		end
	end

	// magnitude stage: larger magnitude and null detect
	always_ff @(posedge clk) begin
		vx_sn[0]               <= vx_in;
		vy_sn[0]               <= vy_in;
		m_sn[0]                <= (mx > my) ? mx : my;
		flags_sn[0].null_vec   <= (vx_in == '0) && (vy_in == '0);
		flags_sn[0].degenerate <= deg_in;
	end

	// shift search: 16, 8, 4, 2, 1
	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int SH  = 1 << (NS - 1 - j);
		localparam int LIM = qth_pkg::NORM_TOP + 1 - SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[j+1] <= 1'b0;
			end else begin
				valid_sn[j+1] <= valid_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			flags_sn[j+1] <= flags_sn[j];
			if ((m_sn[j] >> LIM) == '0) begin
				vx_sn[j+1] <= vx_sn[j] <<< SH;
				vy_sn[j+1] <= vy_sn[j] <<< SH;
				m_sn[j+1]  <= m_sn[j] << SH;
			end else begin
				vx_sn[j+1] <= vx_sn[j];
				vy_sn[j+1] <= vy_sn[j];
				m_sn[j+1]  <= m_sn[j];
			end
		end
	end

	assign nvx = -vx_sn[NS];
	assign nvy = -vy_sn[NS];

	// pre-rotation valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_sn[NS];
		end
	end

	// pre-rotation into the right half-plane
	always_ff @(posedge clk) begin
		flags_out <= flags_sn[NS];
		if (vx_sn[NS][qth_pkg::VEC_W-1]) begin
			vec_out.vx <= nvx;
			vec_out.vy <= nvy;
			if (nvy[qth_pkg::VEC_W-1] || (nvy == '0)) begin
				vec_out.acc <= qth_pkg::ANGLE_PI;
			end else begin
				vec_out.acc <= -qth_pkg::ANGLE_PI;
			end
		end else begin
			vec_out.vx  <= vx_sn[NS];
			vec_out.vy  <= vy_sn[NS];
			vec_out.acc <= '0;
		end
	end

endmodule

>>> src/qth_cstage.sv
// ----------------------------------------------------------------------------
// qth_cstage: one CORDIC vectoring iteration
// Rotates the vector towards the x axis by atan(2^-STAGE_IDX) and books the
// angle, with a register stage on the output.
// ----------------------------------------------------------------------------
module qth_cstage #(
	parameter int STAGE_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  qth_pkg::vec_t   vec_in,
	input  qth_pkg::flags_t flags_in,
	output logic            valid_out,
	output qth_pkg::vec_t   vec_out,
	output qth_pkg::flags_t flags_out
);

	localparam logic signed [qth_pkg::ACC_W-1:0] ANG = qth_pkg::ATAN_TAB[STAGE_IDX];

	logic signed [qth_pkg::VEC_W-1:0] dx, dy;

	assign dx = vec_in.vy >>> STAGE_IDX;
	assign dy = vec_in.vx >>> STAGE_IDX;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	// micro-rotation, direction from the sign of y
	always_ff @(posedge clk) begin
		flags_out <= flags_in;
		if (!vec_in.vy[qth_pkg::VEC_W-1]) begin
			vec_out.vx  <= vec_in.vx + dx;
			vec_out.vy  <= vec_in.vy - dy;
			vec_out.acc <= vec_in.acc + ANG;
		end else begin
			vec_out.vx  <= vec_in.vx - dx;
			vec_out.vy  <= vec_in.vy + dy;
			vec_out.acc <= vec_in.acc - ANG;
		end
	end

endmodule

>>> src/quaternion_to_heading.sv
// ----------------------------------------------------------------------------
// quaternion_to_heading: heading angle of a Q2.14 quaternion
// A quaternion is taken on any cycle with start high and busy low; busy is
// always low, so one word is accepted every clock. The heading leaves
// CORDIC_ITERATIONS + 10 register stages later (products, sums, magnitude,
// five normalising shift steps, pre-rotation, one stage per CORDIC
// iteration, output rounding): done is high for exactly one cycle with the
// result on heading, and the receiver must take it then, as it cannot stall
// the pipeline. The angle is signed, 32768 units per pi. An all-zero
// quaternion gives angle 0 with degenerate set; an axis along z gives angle
// 0 with degenerate clear.
// ----------------------------------------------------------------------------
module quaternion_to_heading #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qth_pkg::quat_t    quat,
	output logic              done,
	output qth_pkg::heading_t heading
);

	localparam int N = CORDIC_ITERATIONS;

	logic                             valid_s2;
	logic signed [qth_pkg::VEC_W-1:0] vx_s2, vy_s2;
	logic                             deg_s2;

	logic [N:0]      valid_c;
	qth_pkg::vec_t   vec_c   [N+1];
	qth_pkg::flags_t flags_c [N+1];

	logic signed [qth_pkg::ACC_W-1:0] rounded;

	// the pipeline never holds off a word
	assign busy = 1'b0;

	qth_form u_form (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start),
		.quat     (quat),
		.valid_s2 (valid_s2),
		.vx_s2    (vx_s2),
		.vy_s2    (vy_s2),
		.deg_s2   (deg_s2)
	);

	qth_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.vx_in     (vx_s2),
		.vy_in     (vy_s2),
		.deg_in    (deg_s2),
		.valid_out (valid_c[0]),
		.vec_out   (vec_c[0]),
		.flags_out (flags_c[0])
	);

	// CORDIC iteration chain
	for (genvar i = 0; i < N; i++) begin : g_cordic
		qth_cstage #(
			.STAGE_IDX (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[i]),
			.vec_in    (vec_c[i]),
			.flags_in  (flags_c[i]),
			.valid_out (valid_c[i+1]),
			.vec_out   (vec_c[i+1]),
			.flags_out (flags_c[i+1])
		);
	end

	// round half up to the output angle
	assign rounded = vec_c[N].acc + qth_pkg::ROUND_HALF;

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_c[N];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		heading.degenerate <= flags_c[N].degenerate;
		if (flags_c[N].null_vec) begin
			heading.heading_angle <= '0;
		end else begin
			heading.heading_angle <= rounded[qth_pkg::ROUND_POS+15:qth_pkg::ROUND_POS];
		end
	end

endmodule

>>> tb/tb_quaternion_to_heading.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_heading: self-checking bench for the heading pipeline
// Feeds quaternion words through the start/busy handshake, first from a short
// table of corner cases, then at random with idle gaps (none in one span), and checks every
// heading word that leaves on done against its typed heading or a bit-exact CORDIC model kept here.
// ----------------------------------------------------------------------------
module tb_quaternion_to_heading;

	localparam int ITERATIONS   = 16;
	localparam int LATENCY      = ITERATIONS + 10;
	localparam int RANDOM_WORDS = 1500;
	localparam int IDLE_PCT     = 21;
	localparam int QUIET_FIRST  = 500;   // words in this span go out back to back
	localparam int QUIET_LAST   = 799;
	localparam int STALL_LIMIT  = 2000;
	localparam int REPORT_MAX   = 10;

	localparam longint HALF_TURN  = 64'sd2147483648;   // pi in accumulator units
	localparam longint NORM_FLOOR = 64'sd2147483648;   // larger magnitude raised to bit 31

	// atan(2^-i), 2^31 units = pi
	localparam longint ARCTAN [31] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
		64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
		64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
		64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
		64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
		64'sd652,       64'sd326,       64'sd163,       64'sd81,
		64'sd41,        64'sd20,        64'sd10,        64'sd5,
		64'sd3,         64'sd1,         64'sd1
	};

	// one row of the corner-case table: a fixed heading when typed, else predicted
	typedef struct packed {
		logic              typed;
		qth_pkg::heading_t want;
		qth_pkg::quat_t    q;
	} stim_row_t;

	localparam int CORNER_ROWS = 24;
	localparam stim_row_t CORNERS [CORNER_ROWS] = '{
		// all-zero quaternion
		'{1'b1, '{16'sd0, 1'b1}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		// rotated x axis along z, heading flattened to zero
		'{1'b1, '{16'sd0, 1'b0}, '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0}},
		'{1'b1, '{16'sd0, 1'b0}, '{16'sh8000, 16'sd0, 16'sh8000, 16'sd0}},
		'{1'b1, '{16'sd0, 1'b0}, '{16'sd0, 16'sh8000, 16'sd0, 16'sh8000}},
		// identity and its negative
		'{1'b0, '0, '{16'sh7fff, 16'sd0, 16'sd0, 16'sd0}},
		'{1'b0, '0, '{16'sh8000, 16'sd0, 16'sd0, 16'sd0}},
		// half turn about z, result wraps to -pi
		'{1'b0, '0, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}},
		// quarter turns
		'{1'b0, '0, '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}},
		'{1'b0, '0, '{16'sd11585, 16'sd0, 16'sd0, -16'sd11585}},
		// field extremes
		'{1'b0, '0, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}},
		'{1'b0, '0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}},
		'{1'b0, '0, '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}},
		'{1'b0, '0, '{16'sd0, 16'sh7fff, 16'sd0, 16'sd0}},
		'{1'b0, '0, '{16'sd0, 16'sd0, 16'sh7fff, 16'sd0}},
		// tiny vectors, longest normalising shift; one row with a near-cancelling x part
		'{1'b0, '0, '{16'sd0, 16'sd1, 16'sd0, 16'sd0}},
		'{1'b0, '0, '{16'sd0, 16'sd0, 16'sd1, 16'sd0}},
		'{1'b0, '0, '{16'sd1, 16'sd0, 16'sd0, 16'sd1}},
		'{1'b0, '0, '{16'sd0, 16'sd1, -16'sd1, 16'sd0}},
		'{1'b0, '0, '{16'sd0, 16'sh8000, 16'sh7fff, 16'sd0}},
		'{1'b0, '0, '{-16'sd1, -16'sd1, -16'sd1, -16'sd1}},
		'{1'b0, '0, '{16'sd0, 16'sd0, 16'sd0, -16'sd1}},
		// headings just below zero
		'{1'b0, '0, '{16'sd16384, 16'sd0, 16'sd0, -16'sd1}},
		'{1'b0, '0, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd1}},
		// alternating bit patterns
		'{1'b0, '0, '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}}
	};

	localparam logic [15:0] EDGE_VALUES [5] = '{16'h8000, 16'h7fff, 16'h0000,
		16'hffff, 16'h0001};

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	qth_pkg::quat_t    quat;
	logic              done;
	qth_pkg::heading_t heading;

	qth_pkg::heading_t heading_q [$];
	qth_pkg::heading_t oldest;
	int                fail_count;
	int                stall_cycles;

	quaternion_to_heading #(
		.CORDIC_ITERATIONS(ITERATIONS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.quat    (quat),
		.done    (done),
		.heading (heading)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// heading of one quaternion: exact products, normalise, CORDIC vectoring
	function automatic qth_pkg::heading_t compute_heading(input qth_pkg::quat_t q);
		longint            w, x, y, z, vx, vy, acc, dx, dy, mx, my, top, res;
		int                i, s;
		qth_pkg::heading_t h;
		w = longint'(q.quat_w);
		x = longint'(q.quat_x);
		y = longint'(q.quat_y);
		z = longint'(q.quat_z);
		h = '0;
		if (w == 0 && x == 0 && y == 0 && z == 0) begin
			h.degenerate = 1'b1;
			return h;
		end
		vx = w * w + x * x - y * y - z * z;
		vy = 2 * (x * y + w * z);
		if (vx == 0 && vy == 0)
			return h;
		mx = (vx < 0) ? -vx : vx;
		my = (vy < 0) ? -vy : vy;
		top = (mx > my) ? mx : my;
		while (top < NORM_FLOOR) begin
			vx = vx * 2;
			vy = vy * 2;
			top = top * 2;
		end
		// left half-plane: turn by pi first
		acc = 0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			acc = (vy <= 0) ? HALF_TURN : -HALF_TURN;
		end
		for (i = 0; i < ITERATIONS; i++) begin
			s = (i < 62) ? i : 62;
			dx = vy >>> s;
			dy = vx >>> s;
			if (vy >= 0) begin
				vx = vx + dx;
				vy = vy - dy;
				if (i < 31)
					acc = acc + ARCTAN[i];
			end else begin
				vx = vx - dx;
				vy = vy + dy;
				if (i < 31)
					acc = acc - ARCTAN[i];
			end
		end
		res = (acc + 64'sd32768) >>> 16;
		h.heading_angle = res[15:0];
		return h;
	endfunction

	// offer one word, idling at random first if may_idle, and log what it must give
	task automatic send_word(input qth_pkg::quat_t q, input qth_pkg::heading_t want,
			input bit may_idle);
		while (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			quat  <= qth_pkg::quat_t'({$urandom, $urandom});
			@(posedge clk);
		end
		start <= 1'b1;
		quat  <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		heading_q.push_back(want);
	endtask

	// stimulus
	initial begin
		qth_pkg::quat_t q;
		int             k, n, pick;
		logic [15:0]    r;
		arst_n <= 1'b0;
		start  <= 1'b0;
		quat   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases
		for (k = 0; k < CORNER_ROWS; k++)
			send_word(CORNERS[k].q,
				CORNERS[k].typed ? CORNERS[k].want : compute_heading(CORNERS[k].q), 1'b1);

		// random words, with a mix of shapes
		for (n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			r = 16'($urandom);
			q = qth_pkg::quat_t'({$urandom, $urandom});
			if (pick >= 60 && pick < 75) begin
				// small parts, deep normalisation
				q.quat_w = 16'(int'($urandom_range(0, 16)) - 8);
				q.quat_x = 16'(int'($urandom_range(0, 16)) - 8);
				q.quat_y = 16'(int'($urandom_range(0, 16)) - 8);
				q.quat_z = 16'(int'($urandom_range(0, 16)) - 8);
			end else if (pick >= 75 && pick < 85) begin
				q.quat_w = EDGE_VALUES[$urandom_range(0, 4)];
				q.quat_x = EDGE_VALUES[$urandom_range(0, 4)];
				q.quat_y = EDGE_VALUES[$urandom_range(0, 4)];
				q.quat_z = EDGE_VALUES[$urandom_range(0, 4)];
			end else if (pick >= 85 && pick < 93) begin
				// axis along z: no xy component
				q = '0;
				if ($urandom_range(0, 1)) begin
					q.quat_w = r;
					q.quat_y = $urandom_range(0, 1) ? r : -r;
				end else begin
					q.quat_x = r;
					q.quat_z = $urandom_range(0, 1) ? r : -r;
				end
			end else if (pick >= 93) begin
				// heading of exactly zero or pi
				q = '0;
				case ($urandom_range(0, 2))
					0: q.quat_x = r;
					1: q.quat_y = r;
					default: q.quat_z = r;
				endcase
			end
			send_word(q, compute_heading(q), !(n >= QUIET_FIRST && n <= QUIET_LAST));
		end
		start <= 1'b0;

		// drain
		while (heading_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		fail_count = fail_count + heading_q.size();
		if (fail_count == 0)
			$display("tb_quaternion_to_heading: done, clean");
		else
			$display("tb_quaternion_to_heading: done, errors");
		$finish;
	end

	// result check against the oldest logged heading
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (heading_q.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$display("unexpected word: heading %0d degenerate %0b",
						heading.heading_angle, heading.degenerate);
				fail_count++;
			end else begin
				oldest = heading_q.pop_front();
				if (heading.heading_angle !== oldest.heading_angle
						|| heading.degenerate !== oldest.degenerate) begin
					if (fail_count < REPORT_MAX)
						$display("mismatch: heading %0d/%0d degenerate %0b/%0b (exp/act)",
							oldest.heading_angle, heading.heading_angle,
							oldest.degenerate, heading.degenerate);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_quaternion_to_heading: done, errors");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

endmodule
